// ----- rtl/ile_pkg.sv -----
package ile_pkg;

    localparam int CAPACITY = 32;
    localparam int DATA_W   = 32;
    localparam int ACT_W    = 3;
    localparam int POS_W    = 6;
    localparam int KIND_W   = 3;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef enum logic [ACT_W-1:0] {
        ACT_PRINT        = 3'd0,
        ACT_INSERT       = 3'd1,
        ACT_REMOVE       = 3'd2,
        ACT_REMOVE_ALL   = 3'd3,
        ACT_NEIGHBOR_MAX = 3'd4
    } t_action;

    typedef enum logic [KIND_W-1:0] {
        KIND_VALUE     = 3'd0,
        KIND_ERROR     = 3'd1,
        KIND_EMPTY     = 3'd2,
        KIND_NOT_FOUND = 3'd3,
        KIND_COUNT     = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_ROTATE,
        CELL_INSERT,
        CELL_DELETE
    } t_cell_op;

    typedef struct packed {
        t_cell_op          op;
        logic [CMP_W-1:0]  pos;
        logic [DATA_W-1:0] val;
    } t_cell_ctrl;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROTATE,
        ST_SHIFT,
        ST_SCAN,
        ST_EMIT
    } t_state;

endpackage

// ----- rtl/ile_if.sv -----
interface ile_cmd_if;
    logic                             valid;
    logic                             ready;
    logic        [ile_pkg::ACT_W-1:0] action;
    logic        [ile_pkg::POS_W-1:0] position;
    logic signed [ile_pkg::DATA_W-1:0] item_value;

    modport source (output valid, output action, output position, output item_value,
                    input ready);
    modport sink   (input valid, input action, input position, input item_value,
                    output ready);
endinterface

interface ile_res_if;
    logic                              valid;
    logic                              ready;
    logic        [ile_pkg::KIND_W-1:0] kind;
    logic signed [ile_pkg::DATA_W-1:0] data;
    logic                              last;

    modport source (output valid, output kind, output data, output last, input ready);
    modport sink   (input valid, input kind, input data, input last, output ready);
endinterface

// ----- rtl/indexed_list_engine.sv -----
// ordered list of signed 32-bit words held in a row of shift cells
//
// channels: i_cmd carries one command word (action, position, item_value),
// o_res carries result words (kind, data, last); both use valid/ready and a
// word moves on a clock edge where both are high
//
// steps per command, on the cell row of CAPACITY entries:
//   insert            written into the row when taken, no result unless it fails
//   print             one full rotation of the row, one word per entry
//   remove            full rotation to read the entry, then shift, then result
//   neighbour max     full rotation to read both neighbours, then the result
//   remove all        entries checked in turn from the head, a match closed up
//                     in place, then the result once the end is seen
//   errors/empty      straight to the result register
// a new command is taken once the previous one is finished in the row, even
// while its final result word still sits in the output register
//
// reset (synchronous, active low) empties the list and drops any pending
// result; list contents themselves are not cleared
// a stalled receiver freezes the print rotation and holds the result word
module indexed_list_engine (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ile_cmd_if.sink    i_cmd,
    ile_res_if.source  o_res
);

    localparam int CAP = ile_pkg::CAPACITY;
    localparam int DW  = ile_pkg::DATA_W;
    localparam int CW  = ile_pkg::CNT_W;
    localparam int PW  = ile_pkg::CMP_W;

    // control state
    ile_pkg::t_state r_state, n_state;
    logic [CW-1:0]   r_cnt, n_cnt;       // current list length
    logic [CW-1:0]   r_step, n_step;     // rotation step or scan pointer
    logic [CW-1:0]   r_hits, n_hits;     // matches removed so far
    logic [ile_pkg::ACT_W-1:0] r_act, n_act;
    logic [PW-1:0]   r_pos, n_pos;
    logic [DW-1:0]   r_val, n_val;
    logic [DW-1:0]   r_left, n_left;     // pending data / left neighbour
    logic [DW-1:0]   r_right, n_right;   // right neighbour
    ile_pkg::t_kind  r_pkind, n_pkind;

    // output register
    logic            r_ov;
    ile_pkg::t_kind  r_okind;
    logic [DW-1:0]   r_odata;
    logic            r_olast;
    logic            w_load;
    ile_pkg::t_kind  w_lkind;
    logic [DW-1:0]   w_ldata;
    logic            w_llast;

    // cell row
    ile_pkg::t_cell_ctrl w_ctrl;
    logic [DW-1:0]       w_data  [CAP];
    logic [DW-1:0]       w_left  [CAP];
    logic [DW-1:0]       w_right [CAP];
    logic [CAP-1:0]      w_match;

    logic          w_accept;
    logic [PW-1:0] w_in_pos;
    logic [PW-1:0] w_n;
    logic [PW-1:0] w_step_c;
    logic          w_can_emit;
    logic          w_last_step;
    logic          w_rot_go;
    logic          w_scan_done;
    logic          w_scan_hit;
    logic          w_ins_err;
    logic          w_pos_err;
    logic [DW-1:0] w_head;

    for (genvar g = 0; g < CAP; g++) begin : g_cell
        if (g == 0) begin : g_first
            assign w_left[g] = '0;
        end else begin : g_inner_l
            assign w_left[g] = w_data[g-1];
        end
        // tail wraps to the head so a rotation restores the row
        if (g == CAP - 1) begin : g_tail
            assign w_right[g] = w_data[0];
        end else begin : g_inner_r
            assign w_right[g] = w_data[g+1];
        end

        // match key comes from the held command value
        ile_cell u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (w_ctrl),
            .i_idx   (PW'(g)),
            .i_key   (r_val),
            .i_left  (w_left[g]),
            .i_right (w_right[g]),
            .o_data  (w_data[g]),
            .o_match (w_match[g])
        );
    end

    assign w_accept    = i_cmd.valid && (r_state == ile_pkg::ST_IDLE);
    assign i_cmd.ready = (r_state == ile_pkg::ST_IDLE);
    assign w_in_pos    = PW'(i_cmd.position);
    assign w_n         = PW'(r_cnt);
    assign w_step_c    = PW'(r_step);
    assign w_head      = w_data[0];
    assign w_can_emit  = !r_ov || o_res.ready;
    assign w_last_step = (r_step == CW'(CAP - 1));
    // print waits on the receiver only while real entries pass the head
    assign w_rot_go    = (r_act != ile_pkg::ACT_PRINT) || (w_step_c >= w_n) || w_can_emit;
    assign w_scan_done = (w_step_c >= w_n);
    assign w_scan_hit  = w_match[r_step[ile_pkg::IDX_W-1:0]];
    assign w_ins_err   = (w_in_pos > w_n) || (r_cnt >= CW'(CAP));
    assign w_pos_err   = (w_in_pos >= w_n);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ile_pkg::ST_IDLE: begin
                if (w_accept) begin
                    case (i_cmd.action)
                        ile_pkg::ACT_PRINT: begin
                            n_state = (r_cnt == '0) ? ile_pkg::ST_EMIT : ile_pkg::ST_ROTATE;
                        end
                        ile_pkg::ACT_INSERT: begin
                            n_state = w_ins_err ? ile_pkg::ST_EMIT : ile_pkg::ST_IDLE;
                        end
                        ile_pkg::ACT_REMOVE, ile_pkg::ACT_NEIGHBOR_MAX: begin
                            n_state = w_pos_err ? ile_pkg::ST_EMIT : ile_pkg::ST_ROTATE;
                        end
                        ile_pkg::ACT_REMOVE_ALL: begin
                            n_state = (r_cnt == '0) ? ile_pkg::ST_EMIT : ile_pkg::ST_SCAN;
                        end
                        default: begin
                            n_state = ile_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            ile_pkg::ST_ROTATE: begin
                if (w_rot_go && w_last_step) begin
                    if (r_act == ile_pkg::ACT_REMOVE) begin
                        n_state = ile_pkg::ST_SHIFT;
                    end else if (r_act == ile_pkg::ACT_NEIGHBOR_MAX) begin
                        n_state = ile_pkg::ST_EMIT;
                    end else begin
                        n_state = ile_pkg::ST_IDLE;
                    end
                end
            end
            ile_pkg::ST_SHIFT: begin
                n_state = ile_pkg::ST_EMIT;
            end
            ile_pkg::ST_SCAN: begin
                if (w_scan_done) begin
                    n_state = ile_pkg::ST_EMIT;
                end
            end
            ile_pkg::ST_EMIT: begin
                if (w_can_emit) begin
                    n_state = ile_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = ile_pkg::ST_IDLE;
            end
        endcase
    end

    // cell commands, working registers and result loads
    always_comb begin
        n_cnt   = r_cnt;
        n_step  = r_step;
        n_hits  = r_hits;
        n_act   = r_act;
        n_pos   = r_pos;
        n_val   = r_val;
        n_left  = r_left;
        n_right = r_right;
        n_pkind = r_pkind;
        w_ctrl  = '{op: ile_pkg::CELL_HOLD, pos: r_pos, val: r_val};
        w_load  = 1'b0;
        w_lkind = ile_pkg::KIND_VALUE;
        w_ldata = r_left;
        w_llast = 1'b1;
        case (r_state)
            ile_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_act   = i_cmd.action;
                    n_pos   = w_in_pos;
                    n_val   = i_cmd.item_value;
                    n_step  = '0;
                    n_hits  = '0;
                    n_left  = '0;
                    n_right = '0;
                    n_pkind = ile_pkg::KIND_VALUE;
                    case (i_cmd.action)
                        ile_pkg::ACT_PRINT: begin
                            n_pkind = ile_pkg::KIND_EMPTY;
                        end
                        ile_pkg::ACT_INSERT: begin
                            if (w_ins_err) begin
                                n_pkind = ile_pkg::KIND_ERROR;
                            end else begin
                                w_ctrl = '{op: ile_pkg::CELL_INSERT, pos: w_in_pos,
                                           val: i_cmd.item_value};
                                n_cnt  = r_cnt + CW'(1);
                            end
                        end
                        ile_pkg::ACT_REMOVE, ile_pkg::ACT_NEIGHBOR_MAX: begin
                            if (w_pos_err) begin
                                n_pkind = ile_pkg::KIND_ERROR;
                            end
                        end
                        ile_pkg::ACT_REMOVE_ALL: begin
                            n_pkind = ile_pkg::KIND_NOT_FOUND;
                        end
                        default: begin
                            n_pkind = ile_pkg::KIND_VALUE;
                        end
                    endcase
                end
            end
            ile_pkg::ST_ROTATE: begin
                if (w_rot_go) begin
                    w_ctrl.op = ile_pkg::CELL_ROTATE;
                    n_step    = r_step + CW'(1);
                    case (r_act)
                        ile_pkg::ACT_PRINT: begin
                            if (w_step_c < w_n) begin
                                w_load  = 1'b1;
                                w_lkind = ile_pkg::KIND_VALUE;
                                w_ldata = w_head;
                                w_llast = (w_step_c + PW'(1) == w_n);
                            end
                        end
                        ile_pkg::ACT_REMOVE: begin
                            if (w_step_c == r_pos) begin
                                n_left = w_head;
                            end
                        end
                        ile_pkg::ACT_NEIGHBOR_MAX: begin
                            if (w_step_c + PW'(1) == r_pos) begin
                                n_left = w_head;
                            end
                            if ((w_step_c == r_pos + PW'(1)) && (r_pos + PW'(1) < w_n)) begin
                                n_right = w_head;
                            end
                        end
                        default: begin
                            n_left = r_left;
                        end
                    endcase
                end
            end
            ile_pkg::ST_SHIFT: begin
                w_ctrl.op = ile_pkg::CELL_DELETE;
                n_cnt     = r_cnt - CW'(1);
            end
            ile_pkg::ST_SCAN: begin
                if (w_scan_done) begin
                    n_pkind = (r_hits == '0) ? ile_pkg::KIND_NOT_FOUND : ile_pkg::KIND_COUNT;
                    n_left  = DW'(r_hits);
                end else if (w_scan_hit) begin
                    // close the gap, pointer stays on the same place
                    w_ctrl.op  = ile_pkg::CELL_DELETE;
                    w_ctrl.pos = w_step_c;
                    n_cnt      = r_cnt - CW'(1);
                    n_hits     = r_hits + CW'(1);
                end else begin
                    n_step = r_step + CW'(1);
                end
            end
            ile_pkg::ST_EMIT: begin
                if (w_can_emit) begin
                    w_load  = 1'b1;
                    w_lkind = r_pkind;
                    w_llast = 1'b1;
                    if ((r_act == ile_pkg::ACT_NEIGHBOR_MAX) &&
                        ($signed(r_right) > $signed(r_left))) begin
                        w_ldata = r_right;
                    end else begin
                        w_ldata = r_left;
                    end
                end
            end
            default: begin
                w_load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ile_pkg::ST_IDLE;
            r_cnt   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (w_load) begin
                r_ov <= 1'b1;
            end else if (o_res.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // working and payload registers
    always_ff @(posedge i_clk) begin
        r_step  <= n_step;
        r_hits  <= n_hits;
        r_act   <= n_act;
        r_pos   <= n_pos;
        r_val   <= n_val;
        r_left  <= n_left;
        r_right <= n_right;
        r_pkind <= n_pkind;
        if (w_load) begin
            r_okind <= w_lkind;
            r_odata <= w_ldata;
            r_olast <= w_llast;
        end
    end

    assign o_res.valid = r_ov;
    assign o_res.kind  = r_okind;
    assign o_res.data  = r_odata;
    assign o_res.last  = r_olast;

endmodule

// ----- rtl/ile_cell.sv -----
module ile_cell (
    input  logic                           i_clk,
    input  ile_pkg::t_cell_ctrl            i_ctrl,
    input  logic [ile_pkg::CMP_W-1:0]      i_idx,
    input  logic [ile_pkg::DATA_W-1:0]     i_key,
    input  logic [ile_pkg::DATA_W-1:0]     i_left,
    input  logic [ile_pkg::DATA_W-1:0]     i_right,
    output logic [ile_pkg::DATA_W-1:0]     o_data,
    output logic                           o_match
);

    logic [ile_pkg::DATA_W-1:0] r_data;
    logic [ile_pkg::DATA_W-1:0] n_data;

    always_comb begin
        case (i_ctrl.op)
            ile_pkg::CELL_ROTATE: begin
                n_data = i_right;
            end
            ile_pkg::CELL_INSERT: begin
                if (i_idx > i_ctrl.pos) begin
                    n_data = i_left;
                end else if (i_idx == i_ctrl.pos) begin
                    n_data = i_ctrl.val;
                end else begin
                    n_data = r_data;
                end
            end
            ile_pkg::CELL_DELETE: begin
                n_data = (i_idx >= i_ctrl.pos) ? i_right : r_data;
            end
            default: begin
                n_data = r_data;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data  = r_data;
    assign o_match = (r_data == i_key);

endmodule

// ----- rtl/ile_checker.sv -----
module ile_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_cmd_valid,
    input logic                          i_cmd_ready,
    input logic [ile_pkg::ACT_W-1:0]     i_cmd_action,
    input logic                          i_res_valid,
    input logic                          i_res_ready,
    input logic [ile_pkg::KIND_W-1:0]    i_res_kind,
    input logic [ile_pkg::DATA_W-1:0]    i_res_data,
    input logic                          i_res_last
);

    logic w_cmd_acc;
    logic w_busy_cmd;

    assign w_cmd_acc  = i_cmd_valid && i_cmd_ready;
    assign w_busy_cmd = (i_cmd_action == ile_pkg::ACT_PRINT) ||
                        (i_cmd_action == ile_pkg::ACT_REMOVE) ||
                        (i_cmd_action == ile_pkg::ACT_REMOVE_ALL) ||
                        (i_cmd_action == ile_pkg::ACT_NEIGHBOR_MAX);

    // stalled result word stays offered
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid)
        else $error("result word dropped while stalled");

    a_res_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=>
            $stable(i_res_kind) && $stable(i_res_data) && $stable(i_res_last))
        else $error("result word changed while stalled");

    // print, remove, remove all and neighbour max keep the block busy after they are taken
    a_busy_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd_acc && w_busy_cmd |=> !i_cmd_ready)
        else $error("command taken without busy period");

    // unused action codes are dropped without effect
    a_unused_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd_acc && (i_cmd_action > ile_pkg::ACT_NEIGHBOR_MAX) |=> i_cmd_ready)
        else $error("unused action code stalled the block");

    // only listed values can be followed by more words
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && (i_res_kind != ile_pkg::KIND_VALUE) |-> i_res_last)
        else $error("status word without last");

endmodule

bind indexed_list_engine ile_checker u_ile_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_cmd_valid  (i_cmd.valid),
    .i_cmd_ready  (i_cmd.ready),
    .i_cmd_action (i_cmd.action),
    .i_res_valid  (o_res.valid),
    .i_res_ready  (o_res.ready),
    .i_res_kind   (o_res.kind),
    .i_res_data   (o_res.data),
    .i_res_last   (o_res.last)
);

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

    // action codes above the last defined one are ignored by the block
    localparam logic [ile_pkg::ACT_W-1:0] ACT_RESERVED_FIRST = 3'd5;
    localparam logic [ile_pkg::ACT_W-1:0] ACT_RESERVED_LAST  = 3'd7;

    localparam int unsigned ITEM_TARGET = 310;
    localparam int unsigned TAIL_CYCLES = ile_pkg::CAPACITY + 8;

    typedef struct packed {
        logic        [ile_pkg::ACT_W-1:0]  act;
        logic        [ile_pkg::POS_W-1:0]  pos;
        logic signed [ile_pkg::DATA_W-1:0] val;
    } t_command;

    typedef struct {
        ile_pkg::t_kind                    kind;
        logic signed [ile_pkg::DATA_W-1:0] data;
        logic                              last;
    } t_result;

    logic i_clk;
    logic i_rst_n;

    ile_cmd_if cmd_bus ();
    ile_res_if res_bus ();

    indexed_list_engine DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_bus),
        .o_res   (res_bus)
    );

    // list as it should stand after every accepted command word
    logic signed [ile_pkg::DATA_W-1:0] list_model [ile_pkg::CAPACITY];
    int unsigned                       list_len;
    t_result                           awaited_results [$];
    t_command                          command_queue [$];

    int unsigned failures;
    int unsigned items_sent;
    bit          quiet;
    int unsigned send_gap;
    int unsigned hold_off;

    initial begin
        i_clk               = 1'b0;
        i_rst_n             = 1'b0;
        cmd_bus.valid       = 1'b0;
        cmd_bus.action      = '0;
        cmd_bus.position    = '0;
        cmd_bus.item_value  = '0;
        res_bus.ready       = 1'b0;
        list_len            = 0;
        failures            = 0;
        items_sent          = 0;
        quiet               = 1'b0;
        send_gap            = 0;
        hold_off            = 0;
    end

    always #10 i_clk = ~i_clk;

    // mostly short gaps, now and then a long one; none while quiet
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (quiet)
            return 0;
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic void queue_result(ile_pkg::t_kind kind,
                                         logic signed [ile_pkg::DATA_W-1:0] data,
                                         logic last);
        t_result r;
        r.kind = kind;
        r.data = data;
        r.last = last;
        awaited_results.push_back(r);
    endfunction

    // predicted effect of one accepted command word
    function automatic void apply_command(logic [ile_pkg::ACT_W-1:0] act,
                                          logic [ile_pkg::POS_W-1:0] pos,
                                          logic signed [ile_pkg::DATA_W-1:0] val);
        int unsigned                       p;
        int unsigned                       i;
        int unsigned                       kept;
        int unsigned                       hits;
        logic signed [ile_pkg::DATA_W-1:0] lhs;
        logic signed [ile_pkg::DATA_W-1:0] rhs;
        p = pos;
        case (act)
            ile_pkg::ACT_PRINT: begin
                if (list_len == 0)
                    queue_result(ile_pkg::KIND_EMPTY, '0, 1'b1);
                else
                    for (i = 0; i < list_len; i++)
                        queue_result(ile_pkg::KIND_VALUE, list_model[i], i + 1 == list_len);
            end
            ile_pkg::ACT_INSERT: begin
                if (p > list_len || list_len >= ile_pkg::CAPACITY) begin
                    queue_result(ile_pkg::KIND_ERROR, '0, 1'b1);
                end else begin
                    for (i = list_len; i > p; i--)
                        list_model[i] = list_model[i-1];
                    list_model[p] = val;
                    list_len++;
                end
            end
            ile_pkg::ACT_REMOVE: begin
                if (p >= list_len) begin
                    queue_result(ile_pkg::KIND_ERROR, '0, 1'b1);
                end else begin
                    queue_result(ile_pkg::KIND_VALUE, list_model[p], 1'b1);
                    for (i = p; i + 1 < list_len; i++)
                        list_model[i] = list_model[i+1];
                    list_len--;
                end
            end
            ile_pkg::ACT_REMOVE_ALL: begin
                kept = 0;
                hits = 0;
                for (i = 0; i < list_len; i++) begin
                    if (list_model[i] == val)
                        hits++;
                    else begin
                        list_model[kept] = list_model[i];
                        kept++;
                    end
                end
                list_len = kept;
                if (hits == 0)
                    queue_result(ile_pkg::KIND_NOT_FOUND, '0, 1'b1);
                else
                    queue_result(ile_pkg::KIND_COUNT, hits, 1'b1);
            end
            ile_pkg::ACT_NEIGHBOR_MAX: begin
                if (p >= list_len) begin
                    queue_result(ile_pkg::KIND_ERROR, '0, 1'b1);
                end else begin
                    // a missing neighbour counts as zero
                    lhs = (p > 0) ? list_model[p-1] : '0;
                    rhs = (p + 1 < list_len) ? list_model[p+1] : '0;
                    queue_result(ile_pkg::KIND_VALUE, (lhs > rhs) ? lhs : rhs, 1'b1);
                end
            end
            default: ;
        endcase
    endfunction

    // command driver
    always @(posedge i_clk) begin
        t_command w;
        if (!i_rst_n) begin
            cmd_bus.valid <= 1'b0;
        end else if (!cmd_bus.valid || cmd_bus.ready) begin
            if (send_gap != 0) begin
                send_gap--;
                cmd_bus.valid <= 1'b0;
            end else if (command_queue.size() != 0) begin
                w = command_queue.pop_front();
                cmd_bus.valid      <= 1'b1;
                cmd_bus.action     <= w.act;
                cmd_bus.position   <= w.pos;
                cmd_bus.item_value <= w.val;
                send_gap = pick_gap();
            end else begin
                cmd_bus.valid <= 1'b0;
            end
        end
    end

    // result receiver with random stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_bus.ready <= 1'b0;
            hold_off = 0;
        end else if (hold_off != 0) begin
            res_bus.ready <= 1'b0;
            hold_off--;
        end else begin
            res_bus.ready <= 1'b1;
            if (!quiet && $urandom_range(0, 99) < 15)
                hold_off = pick_gap();
        end
    end

    // monitor: check result words first, then predict from the command word
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n) begin
            if (res_bus.valid && res_bus.ready) begin
                if (awaited_results.size() == 0) begin
                    $error("unexpected result word: kind %0d, data %0d, last %0d",
                           res_bus.kind, res_bus.data, res_bus.last);
                    failures++;
                end else begin
                    want = awaited_results.pop_front();
                    if (res_bus.kind !== want.kind) begin
                        $error("kind: expected %0d, got %0d", want.kind, res_bus.kind);
                        failures++;
                    end
                    if (res_bus.data !== want.data) begin
                        $error("data: expected %0d, got %0d", want.data, res_bus.data);
                        failures++;
                    end
                    if (res_bus.last !== want.last) begin
                        $error("last: expected %0d, got %0d", want.last, res_bus.last);
                        failures++;
                    end
                end
            end
            if (cmd_bus.valid && cmd_bus.ready)
                apply_command(cmd_bus.action, cmd_bus.position, cmd_bus.item_value);
        end
    end

    task automatic send(logic [ile_pkg::ACT_W-1:0] act, int unsigned pos,
                        logic signed [ile_pkg::DATA_W-1:0] val);
        t_command w;
        w.act = act;
        w.pos = ile_pkg::POS_W'(pos);
        w.val = val;
        while (command_queue.size() >= 2)
            @(negedge i_clk);
        command_queue.push_back(w);
        if (act <= ile_pkg::ACT_NEIGHBOR_MAX)
            items_sent++;
    endtask

    // hold the sender until every awaited word is back
    task automatic wait_idle();
        do
            @(negedge i_clk);
        while (command_queue.size() != 0 || cmd_bus.valid || awaited_results.size() != 0);
    endtask

    function automatic logic signed [ile_pkg::DATA_W-1:0] pick_value();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return $signed($urandom_range(0, 7)) - 4;
        if (r < 45)
            return 32'sh8000_0000;
        if (r < 50)
            return 32'sh7fff_ffff;
        return $urandom;
    endfunction

    // one command drawn by weight; positions aim at the current length
    task automatic random_command(int unsigned w_ins, int unsigned w_rem, int unsigned w_all,
                                  int unsigned w_nbr, int unsigned w_prn);
        int unsigned                       r;
        int unsigned                       len;
        int unsigned                       pos;
        logic signed [ile_pkg::DATA_W-1:0] val;
        len = list_len;
        r   = $urandom_range(0, w_ins + w_rem + w_all + w_nbr + w_prn - 1);
        val = pick_value();
        if ($urandom_range(0, 9) == 0)
            pos = $urandom_range(0, 63);
        else
            pos = $urandom_range(0, (len > 0) ? len - 1 : 0);
        if (r < w_ins) begin
            if ($urandom_range(0, 4) == 0)
                pos = len;
            send(ile_pkg::ACT_INSERT, pos, val);
        end else if (r < w_ins + w_rem) begin
            send(ile_pkg::ACT_REMOVE, pos, val);
        end else if (r < w_ins + w_rem + w_all) begin
            if (len > 0 && $urandom_range(0, 9) < 7)
                val = list_model[$urandom_range(0, len - 1)];
            send(ile_pkg::ACT_REMOVE_ALL, pos, val);
        end else if (r < w_ins + w_rem + w_all + w_nbr) begin
            send(ile_pkg::ACT_NEIGHBOR_MAX, pos, val);
        end else begin
            send(ile_pkg::ACT_PRINT, pos, val);
        end
    endtask

    // stimulus
    initial begin
        int unsigned               phase;
        int unsigned               span;
        int unsigned               k;
        logic [ile_pkg::ACT_W-1:0] a;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // empty list corner cases
        send(ile_pkg::ACT_PRINT, 0, 0);
        send(ile_pkg::ACT_REMOVE, 0, 0);
        send(ile_pkg::ACT_NEIGHBOR_MAX, 0, 0);
        send(ile_pkg::ACT_REMOVE_ALL, 0, 5);
        send(ile_pkg::ACT_INSERT, 1, 7);
        // build -1, min, -1, max
        send(ile_pkg::ACT_INSERT, 0, 32'sh8000_0000);
        send(ile_pkg::ACT_INSERT, 1, 32'sh7fff_ffff);
        send(ile_pkg::ACT_INSERT, 1, -1);
        send(ile_pkg::ACT_INSERT, 0, -1);
        // neighbour max at both ends, in the middle, and with equal sides
        send(ile_pkg::ACT_NEIGHBOR_MAX, 0, 0);
        send(ile_pkg::ACT_NEIGHBOR_MAX, 3, 0);
        send(ile_pkg::ACT_NEIGHBOR_MAX, 2, 0);
        send(ile_pkg::ACT_NEIGHBOR_MAX, 1, 0);
        send(ile_pkg::ACT_PRINT, 0, 0);
        send(ile_pkg::ACT_INSERT, 63, 1);
        send(ile_pkg::ACT_REMOVE, 4, 0);
        send(ile_pkg::ACT_NEIGHBOR_MAX, 4, 0);
        for (a = ACT_RESERVED_FIRST; a != ACT_RESERVED_LAST; a++)
            send(a, 63, 32'shffff_ffff);
        send(ACT_RESERVED_LAST, 63, 32'shffff_ffff);
        send(ile_pkg::ACT_REMOVE_ALL, 0, -1);
        send(ile_pkg::ACT_REMOVE, 1, 0);
        send(ile_pkg::ACT_REMOVE, 0, 0);
        send(ile_pkg::ACT_PRINT, 0, 0);
        wait_idle();

        // fill past capacity so that full-list inserts are hit
        for (k = 0; k < 40; k++)
            random_command(100, 0, 0, 0, 0);
        send(ile_pkg::ACT_INSERT, ile_pkg::CAPACITY, 9);
        send(ile_pkg::ACT_PRINT, 0, 0);
        wait_idle();

        while (items_sent < ITEM_TARGET) begin
            phase = $urandom_range(0, 9);
            quiet = ($urandom_range(0, 3) == 0);
            span  = $urandom_range(8, 30);
            for (k = 0; k < span; k++) begin
                case (phase)
                    0, 1, 2: random_command(85, 5, 2, 5, 3);
                    3, 4:    random_command(5, 50, 25, 15, 5);
                    5, 6, 7: random_command(35, 20, 10, 25, 10);
                    8:       send(ile_pkg::ACT_W'($urandom_range(0, 7)),
                                  $urandom_range(0, 63), $urandom);
                    default: random_command(30, 10, 5, 15, 40);
                endcase
            end
            if ($urandom_range(0, 2) == 0)
                wait_idle();
        end
        quiet = 1'b0;

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (awaited_results.size() != 0) begin
            $error("%0d result words never arrived", awaited_results.size());
            failures++;
        end
        if (failures == 0)
            $display("[indexed_list_engine] OK");
        else
            $display("[indexed_list_engine] ERROR");
        $finish;
    end

    // watchdog
    initial begin
        #(50_000_000);
        $display("[indexed_list_engine] ERROR");
        $finish;
    end

endmodule
